// ===== rtl/skvt_pkg.sv =====
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and constants for the sorted key/value table unit.
// ----------------------------------------------------------------------------
package skvt_pkg;

	// Default sizing of the table.
	localparam int DEF_TABLE_DEPTH = 4096;
	localparam int DEF_KEY_BITS    = 32;

	// Fixed widths of the request and result fields.
	localparam int OP_BITS    = 2;
	localparam int KEY_W      = 32;
	localparam int PAYLOAD_W  = 64;
	localparam int POS_BITS   = 12;
	localparam int COUNT_BITS = 13;

	// Operation codes of a request.
	localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_BITS-1:0] OP_READ   = 2'd2;

	// Result status codes.
	typedef enum logic [1:0] {
		STS_OK           = 2'd0,
		STS_FULL         = 2'd1,
		STS_NOT_FOUND    = 2'd2,
		STS_OUT_OF_RANGE = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INS_RD,
		ST_INS_CMP,
		ST_LK_RD,
		ST_LK_CMP,
		ST_LK_FIN,
		ST_RD_WAIT,
		ST_FINISH
	} state_t;

	// Source of the memory read address.
	typedef enum logic [1:0] {
		RS_JM1,
		RS_MID,
		RS_LO,
		RS_POS
	} rd_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    latch_in;
		logic    init_ins;
		logic    init_lk;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    mid_ld;
		logic    wr_en;
		logic    wr_shift;
		logic    j_dec;
		logic    lk_step;
		logic    fill_inc;
		logic    set_res;
		status_t res_code;
		logic    res_take_rd;
		logic    load_out;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_BITS-1:0] op;
		logic               full;
		logic               j_zero;
		logic               lo_lt_hi;
		logic               lo_lt_fill;
		logic               pos_lt_fill;
		logic               rd_gt_key;
		logic               rd_eq_key;
	} dp_stat_t;

endpackage

// ===== rtl/skvt_datapath.sv =====
// ----------------------------------------------------------------------------
// skvt_datapath
// Key and payload memories, scan pointers, fill count and result registers.
// ----------------------------------------------------------------------------
module skvt_datapath
	import skvt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int KEY_BITS    = DEF_KEY_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	input  logic [OP_BITS-1:0]    operation,
	input  logic [KEY_W-1:0]      key,
	input  logic [PAYLOAD_W-1:0]  payload,
	input  logic [POS_BITS-1:0]   position,
	output logic [1:0]            status,
	output logic [KEY_W-1:0]      found_key,
	output logic [PAYLOAD_W-1:0]  found_payload,
	output logic [COUNT_BITS-1:0] entry_count
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int PW = ((CW > POS_BITS) ? CW : POS_BITS) + 1;

	logic [KEY_BITS-1:0]  key_mem [TABLE_DEPTH];
	logic [PAYLOAD_W-1:0] pay_mem [TABLE_DEPTH];

	logic [OP_BITS-1:0]    op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [PAYLOAD_W-1:0]  pay_q;
	logic [POS_BITS-1:0]   pos_q;
	logic [CW-1:0]         fill_q;
	logic [CW-1:0]         j_q;
	logic [CW-1:0]         lo_q;
	logic [CW-1:0]         hi_q;
	logic [CW-1:0]         mid_q;
	logic [KEY_BITS-1:0]   rd_key_q;
	logic [PAYLOAD_W-1:0]  rd_pay_q;
	status_t               res_status_q;
	logic [KEY_W-1:0]      res_key_q;
	logic [PAYLOAD_W-1:0]  res_pay_q;
	logic [1:0]            out_status_q;
	logic [KEY_W-1:0]      out_key_q;
	logic [PAYLOAD_W-1:0]  out_pay_q;
	logic [COUNT_BITS-1:0] out_count_q;

	logic [CW:0]     mid_sum;
	logic [CW-1:0]   mid_w;
	logic [CW-1:0]   jm1;
	logic [PW-1:0]   pos_ext;
	logic [PW-1:0]   fill_ext;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wr_addr;
	logic [KEY_BITS-1:0]  wr_key;
	logic [PAYLOAD_W-1:0] wr_pay;

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w    = mid_sum[CW:1];
	assign jm1      = j_q - CW'(1);
	assign pos_ext  = PW'(pos_q);
	assign fill_ext = PW'(fill_q);
	assign wr_addr  = j_q[AW-1:0];
	assign wr_key   = cmd.wr_shift ? rd_key_q : key_q;
	assign wr_pay   = cmd.wr_shift ? rd_pay_q : pay_q;

	always_comb begin
		case (cmd.rd_sel)
			RS_JM1:  rd_addr = jm1[AW-1:0];
			RS_MID:  rd_addr = mid_w[AW-1:0];
			RS_LO:   rd_addr = lo_q[AW-1:0];
			RS_POS:  rd_addr = pos_ext[AW-1:0];
			default: rd_addr = '0;
		endcase
	end

	// Table memories with a registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			key_mem[wr_addr] <= wr_key;
			pay_mem[wr_addr] <= wr_pay;
		end
		if (cmd.rd_en) begin
			rd_key_q <= key_mem[rd_addr];
			rd_pay_q <= pay_mem[rd_addr];
		end
	end

	// Request capture, pointers and result holding.
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q  <= operation;
			key_q <= KEY_BITS'(key);
			pay_q <= payload;
			pos_q <= position;
		end
		if (cmd.init_ins) begin
			j_q <= fill_q;
		end else if (cmd.j_dec) begin
			j_q <= jm1;
		end
		if (cmd.init_lk) begin
			lo_q <= '0;
			hi_q <= fill_q;
		end else if (cmd.lk_step) begin
			if (rd_key_q < key_q) begin
				lo_q <= mid_q + CW'(1);
			end else begin
				hi_q <= mid_q;
			end
		end
		if (cmd.mid_ld) begin
			mid_q <= mid_w;
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res_code;
			res_key_q    <= cmd.res_take_rd ? KEY_W'(rd_key_q) : '0;
			res_pay_q    <= cmd.res_take_rd ? rd_pay_q : '0;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_key_q    <= res_key_q;
			out_pay_q    <= res_pay_q;
			out_count_q  <= COUNT_BITS'(fill_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.fill_inc) begin
			fill_q <= fill_q + CW'(1);
		end
	end

	assign stat.op          = op_q;
	assign stat.full        = (fill_q >= CW'(TABLE_DEPTH));
	assign stat.j_zero      = (j_q == '0);
	assign stat.lo_lt_hi    = (lo_q < hi_q);
	assign stat.lo_lt_fill  = (lo_q < fill_q);
	assign stat.pos_lt_fill = (pos_ext < fill_ext);
	assign stat.rd_gt_key   = (rd_key_q > key_q);
	assign stat.rd_eq_key   = (rd_key_q == key_q);

	assign status        = out_status_q;
	assign found_key     = out_key_q;
	assign found_payload = out_pay_q;
	assign entry_count   = out_count_q;

endmodule

// ===== rtl/skvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// skvt_ctrl
// Sequencer for insert, lookup and read requests and the result handshake.
// ----------------------------------------------------------------------------
module skvt_ctrl
	import skvt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (stat.op)
					OP_INSERT: begin
						if (stat.full) begin
							cmd.set_res  = 1'b1;
							cmd.res_code = STS_FULL;
							state_d      = ST_FINISH;
						end else begin
							cmd.init_ins = 1'b1;
							state_d      = ST_INS_RD;
						end
					end
					OP_LOOKUP: begin
						cmd.init_lk = 1'b1;
						state_d     = ST_LK_RD;
					end
					OP_READ: begin
						if (stat.pos_lt_fill) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RS_POS;
							state_d    = ST_RD_WAIT;
						end else begin
							cmd.set_res  = 1'b1;
							cmd.res_code = STS_OUT_OF_RANGE;
							state_d      = ST_FINISH;
						end
					end
					default: begin
						cmd.set_res  = 1'b1;
						cmd.res_code = STS_OK;
						state_d      = ST_FINISH;
					end
				endcase
			end
			ST_INS_RD: begin
				if (stat.j_zero) begin
					cmd.wr_en    = 1'b1;
					cmd.fill_inc = 1'b1;
					cmd.set_res  = 1'b1;
					cmd.res_code = STS_OK;
					state_d      = ST_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RS_JM1;
					state_d    = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				cmd.wr_en = 1'b1;
				if (stat.rd_gt_key) begin
					cmd.wr_shift = 1'b1;
					cmd.j_dec    = 1'b1;
					state_d      = ST_INS_RD;
				end else begin
					cmd.fill_inc = 1'b1;
					cmd.set_res  = 1'b1;
					cmd.res_code = STS_OK;
					state_d      = ST_FINISH;
				end
			end
			ST_LK_RD: begin
				if (stat.lo_lt_hi) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RS_MID;
					cmd.mid_ld = 1'b1;
					state_d    = ST_LK_CMP;
				end else if (stat.lo_lt_fill) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RS_LO;
					state_d    = ST_LK_FIN;
				end else begin
					cmd.set_res  = 1'b1;
					cmd.res_code = STS_NOT_FOUND;
					state_d      = ST_FINISH;
				end
			end
			ST_LK_CMP: begin
				cmd.lk_step = 1'b1;
				state_d     = ST_LK_RD;
			end
			ST_LK_FIN: begin
				cmd.set_res     = 1'b1;
				cmd.res_code    = stat.rd_eq_key ? STS_OK : STS_NOT_FOUND;
				cmd.res_take_rd = stat.rd_eq_key;
				state_d         = ST_FINISH;
			end
			ST_RD_WAIT: begin
				cmd.set_res     = 1'b1;
				cmd.res_code    = STS_OK;
				cmd.res_take_rd = 1'b1;
				state_d         = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// A result is only moved to the output register when the slot is free.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("result loaded over an unaccepted result");

	// An accepted request always proceeds to decode.
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid) |=> (state_q == ST_DISPATCH))
		else $error("accepted request did not reach decode");

	// The fill count grows only on an insert into a table with room.
	a_fill_insert: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_inc |-> (stat.op == OP_INSERT && !stat.full))
		else $error("fill count advanced outside a legal insert");

	// The table is written only while an insert is in progress.
	a_wr_insert: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (stat.op == OP_INSERT))
		else $error("table written outside an insert");

endmodule

// ===== rtl/sorted_key_value_table_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_key_value_table_unit
// Table of key/value entries held in ascending key order, with insert,
// lookup by key and read by index.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Fields
//   -------  -------------------  ----------------------------------------------
//   in       in_valid / in_stall  operation, key, payload, position
//   out      out_valid/out_stall  status, found_key, found_payload, entry_count
//
// One request is worked on at a time; each request yields exactly one result.
// An insert moves each stored entry with a key above the new one up one
// place through the table memory, one read and one write per entry, and then
// writes the new entry into the gap; an insert into a full table is refused.
// A lookup is a binary search for the first equal key, with about log2(n)
// probes of the memory for n entries; no final read is made when the search
// runs off the top of the table.
// Reset clears the fill count and the handshake state only; the table memory
// is not cleared, since no entry at or above the fill count is ever returned.
// A new request is taken while a finished result still waits at the output;
// the following result is held back until the output register is free.
//
module sorted_key_value_table_unit
	import skvt_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int KEY_BITS    = DEF_KEY_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Request channel.
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [OP_BITS-1:0]    operation,
	input  logic [KEY_W-1:0]      key,
	input  logic [PAYLOAD_W-1:0]  payload,
	input  logic [POS_BITS-1:0]   position,
	// Result channel.
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output logic [KEY_W-1:0]      found_key,
	output logic [PAYLOAD_W-1:0]  found_payload,
	output logic [COUNT_BITS-1:0] entry_count
);

	// Commands and status between the sequencer and the datapath.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The sequencer owns both handshakes and steps through each operation.
	skvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the table memories, the scan pointers, the fill count
	// and the output register that drives the result fields.
	skvt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BITS    (KEY_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.operation     (operation),
		.key           (key),
		.payload       (payload),
		.position      (position),
		.status        (status),
		.found_key     (found_key),
		.found_payload (found_payload),
		.entry_count   (entry_count)
	);

endmodule
